[rtl/batch_median_select_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for batch_median_select
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef BATCH_MEDIAN_SELECT_MACROS_SVH
`define BATCH_MEDIAN_SELECT_MACROS_SVH

// Same-cycle implication.
`define BMS_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define BMS_ASSERT_NXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/bms_pkg.sv]
// ----------------------------------------------------------------------------
// bms_pkg
// Shared constants and types for the batch median selector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bms_pkg;

  // Number of samples one batch can hold (1 to 31).
  localparam int CAPACITY = 16;
  // Width of the fill count, which must hold CAPACITY itself.
  localparam int FILL_W   = $clog2(CAPACITY + 1);
  localparam int SAMPLE_W = 32;
  localparam int COUNT_W  = 5;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_SHIFT = 2'b10
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;  // an input word is taken this cycle
    logic shift;   // move the cell row down by one place
    logic load;    // load the result register and start a new batch
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic              room;  // the row can take another sample
    logic [FILL_W-1:0] fill;  // samples held in the current batch
  } status_t;

endpackage

[rtl/bms_ctrl.sv]
// ----------------------------------------------------------------------------
// bms_ctrl
// Controller: input and output handshakes, drain sequencing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bms_ctrl
  import bms_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  logic    last_sample,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t            state;
  state_t            state_next;
  logic [FILL_W-1:0] shift_left;
  logic [FILL_W-1:0] shift_left_next;
  logic [FILL_W-1:0] batch_size;
  logic              out_free;

  assign in_ready   = (state == ST_IDLE);
  assign out_free   = !out_valid || out_ready;
  // Size of the batch once the current word is in; never zero.
  assign batch_size = status.fill + FILL_W'(status.room);

  always_comb begin
    state_next      = state;
    shift_left_next = shift_left;
    cmd             = '0;
    case (state)
      ST_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid && last_sample) begin
          // The lower middle sample lies (n-1)/2 places up the row.
          shift_left_next = (batch_size - FILL_W'(1)) >> 1;
          state_next      = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        if (shift_left != '0) begin
          cmd.shift       = 1'b1;
          shift_left_next = shift_left - FILL_W'(1);
        end else if (out_free) begin
          cmd.load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      shift_left <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      shift_left <= shift_left_next;
      if (cmd.load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[rtl/bms_datapath.sv]
// ----------------------------------------------------------------------------
// bms_datapath
// Sorted cell row, fill and drop tracking, median arithmetic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bms_datapath
  import bms_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  cmd_t                       cmd,
  input  logic signed [SAMPLE_W-1:0] sample,
  output status_t                    status,
  output logic signed [SAMPLE_W-1:0] median,
  output logic [COUNT_W-1:0]         used_count,
  output logic                       overflowed
);

  logic signed [SAMPLE_W-1:0] cells [CAPACITY];
  logic [CAPACITY-1:0]        gt;
  logic [CAPACITY-1:0]        ins;
  logic [FILL_W-1:0]          fill;
  logic                       drop_seen;
  logic                       room;
  logic                       insert;
  logic signed [SAMPLE_W-1:0] upper;
  logic signed [SAMPLE_W:0]   pair_sum;
  logic signed [SAMPLE_W:0]   pair_adj;
  logic signed [SAMPLE_W-1:0] median_next;

  assign room        = (fill < FILL_W'(CAPACITY));
  assign insert      = cmd.accept && room;
  assign status.room = room;
  assign status.fill = fill;

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [SAMPLE_W-1:0] cell_in;

      // A held cell above the new sample moves up; the sample takes the lowest such cell or the first free one.
      assign gt[i]  = (FILL_W'(i) < fill) && (cells[i] > sample);
      assign ins[i] = gt[i] || (FILL_W'(i) == fill);

      if (i == 0) begin : g_first
        assign cell_in = sample;
      end else begin : g_rest
        assign cell_in = gt[i-1] ? cells[i-1] : sample;
      end

      if (i == CAPACITY - 1) begin : g_top
        always_ff @(posedge clk) begin
          if (insert && ins[i]) begin
            cells[i] <= cell_in;
          end
        end
      end else begin : g_mid
        always_ff @(posedge clk) begin
          if (insert && ins[i]) begin
            cells[i] <= cell_in;
          end else if (cmd.shift) begin
            cells[i] <= cells[i+1];
          end
        end
      end
    end

    if (CAPACITY > 1) begin : g_pair
      assign upper = fill[0] ? cells[0] : cells[1];
    end else begin : g_single
      assign upper = cells[0];
    end
  endgenerate

  // Sum of the middle pair, halved toward zero.
  assign pair_sum    = {cells[0][SAMPLE_W-1], cells[0]} + {upper[SAMPLE_W-1], upper};
  assign pair_adj    = pair_sum + (SAMPLE_W+1)'(pair_sum[SAMPLE_W]);
  assign median_next = pair_adj[SAMPLE_W:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      drop_seen <= 1'b0;
    end else if (cmd.load) begin
      fill      <= '0;
      drop_seen <= 1'b0;
    end else if (cmd.accept) begin
      if (room) begin
        fill <= fill + FILL_W'(1);
      end else begin
        drop_seen <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      median     <= median_next;
      used_count <= COUNT_W'(fill);
      overflowed <= drop_seen;
    end
  end

endmodule

[rtl/batch_median_select.sv]
// ----------------------------------------------------------------------------
// batch_median_select
// Median of a batch of signed samples, kept sorted in a row of cells.
// ----------------------------------------------------------------------------
//
//   channel  | handshake            | payload
//   ---------+----------------------+----------------------------------------
//   input    | in_valid / in_ready  | sample, last_sample
//   output   | out_valid / out_ready| median, used_count, overflowed
//
// A word without the last mark is taken at once: the row inserts it in
// order. For a batch of n, a marked word starts a drain: the row moves down
// (n-1)/2 places until the middle pair sits in its two lowest cells, then
// the result register loads. in_ready is low during the drain.
// The result register holds a word while the next batch fills; a new
// marked word waits at the load step only while that word is still unread.
// Reset is synchronous and empties the batch; cell contents are not cleared.
//
`timescale 1ns / 1ps

module batch_median_select
  import bms_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       last_sample,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] median,
  output logic [COUNT_W-1:0]         used_count,
  output logic                       overflowed
);

  // Command and status between the controller and the datapath.
  cmd_t    cmd;
  status_t status;

  // The controller owns both handshakes and counts the drain steps.
  bms_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .last_sample (last_sample),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .cmd         (cmd)
  );

  // The datapath holds the sorted row and the result register.
  bms_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sample     (sample),
    .status     (status),
    .median     (median),
    .used_count (used_count),
    .overflowed (overflowed)
  );

endmodule

[rtl/bms_checker.sv]
// ----------------------------------------------------------------------------
// bms_checker
// Port-level checks for batch_median_select, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "batch_median_select_macros.svh"

module bms_checker
  import bms_pkg::*;
(
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       last_sample,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [SAMPLE_W-1:0] median,
  input logic [COUNT_W-1:0]         used_count,
  input logic                       overflowed
);

  // A stalled result word stays offered.
  `BMS_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid, "result word dropped while stalled")
  // A stalled result word keeps its median.
  `BMS_ASSERT_NXT(a_med_hold, clk, rst, out_valid && !out_ready, $stable(median), "median changed while stalled")
  // A stalled result word keeps its count and drop flag.
  `BMS_ASSERT_NXT(a_tag_hold, clk, rst, out_valid && !out_ready, $stable(used_count) && $stable(overflowed), "flags changed while stalled")
  // A result never reports an empty batch.
  `BMS_ASSERT_IMP(a_cnt_nz, clk, rst, out_valid, used_count != '0, "result with zero count")
  // Closing a batch always stops input for the drain.
  `BMS_ASSERT_NXT(a_drain, clk, rst, in_valid && in_ready && last_sample, !in_ready, "input still open after last word")

endmodule

bind batch_median_select bms_checker u_bms_checker (.*);

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking bench for batch_median_select
// Sample words go in over a valid/ready channel and medians come back out.
// The bench predicts each median from its own sorted copy of the batch and
// compares every result word, in order, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import bms_pkg::*;

  // Upper limit on consecutive cycles in which neither channel moves a word.
  // The worst correct stretch is the long receiver hold-off plus one drain.
  localparam int WATCHDOG_LIMIT = 3000;
  // Length of the forced receiver hold-off, far longer than any batch drain.
  localparam int LONG_HOLD      = 300;
  // Cycles to wait at the end after the last median has come back.
  localparam int TAIL_CYCLES    = 24;
  localparam int RANDOM_WORDS   = 1000;

  localparam logic signed [SAMPLE_W-1:0] S_MAX = 32'sh7fff_ffff;
  localparam logic signed [SAMPLE_W-1:0] S_MIN = 32'sh8000_0000;

  // One sample word waiting to be offered. A word marked hold_for_drain is
  // not offered until every median already owed has been received.
  typedef struct {
    logic signed [SAMPLE_W-1:0] value;
    logic                       mark;
    bit                         hold_for_drain;
  } sample_word_t;

  // One median result as the block should report it.
  typedef struct {
    logic signed [SAMPLE_W-1:0] median;
    logic [COUNT_W-1:0]         used_count;
    logic                       overflowed;
  } median_word_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] sample = '0;
  logic                       last_sample = 1'b0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] median;
  logic [COUNT_W-1:0]         used_count;
  logic                       overflowed;

  batch_median_select dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample     (sample),
    .last_sample(last_sample),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .median     (median),
    .used_count (used_count),
    .overflowed (overflowed)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Words still to be offered, and medians still owed by the block.
  sample_word_t pending_words[$];
  median_word_t owed_medians[$];

  // The bench's own copy of the batch: a sorted row, how many samples it
  // holds, and whether the current batch has lost a sample to a full row.
  logic signed [SAMPLE_W-1:0] batch_row [CAPACITY];
  int unsigned                batch_fill = 0;
  bit                         batch_dropped = 1'b0;

  int  words_in = 0;
  int  batches_in = 0;
  int  medians_seen = 0;
  int  dropped_batches = 0;
  int  drain_pauses = 0;
  int  mismatches = 0;
  int  stuck_cycles = 0;
  bit [31:0] cyc = '0;

  // Stretches in which neither side idles: one quarter of the time, while cyc[10:9] is 2'b11.
  wire quiet = (cyc[10:9] == 2'b11);

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // A sample value drawn to hit full-range values, many duplicates, and
  // values close to both extremes, where a subtracting compare would wrap.
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0, 1, 2, 3: return $urandom;
      4, 5: return $urandom_range(0, 8) - 4;
      6: return $urandom_range(0, 1) ? S_MAX - $urandom_range(0, 3)
                                     : S_MIN + $urandom_range(0, 3);
      7: return {1'b0, 31'($urandom)} | 32'h4000_0000;
      8: return {1'b1, 31'($urandom)} & 32'hbfff_ffff;
      default: return $urandom_range(0, 1) ? S_MAX : S_MIN;
    endcase
  endfunction

  task automatic queue_word(input logic signed [SAMPLE_W-1:0] value,
                            input logic mark, input bit hold_for_drain);
    sample_word_t w;
    w.value = value;
    w.mark = mark;
    w.hold_for_drain = hold_for_drain;
    pending_words.push_back(w);
  endtask

  // Applies one accepted sample word to the bench's batch copy. Samples are
  // kept ascending by a true signed compare; once the row is full, further
  // samples (a marked one too) are dropped and flagged. A marked word closes
  // the batch and owes one median: the middle sample for an odd count, or
  // for an even count the 33-bit sum of the middle pair halved toward zero.
  task automatic take_sample_word(input logic signed [SAMPLE_W-1:0] value,
                                  input logic mark);
    int                         pos;
    logic signed [SAMPLE_W:0]   pair_sum;
    logic signed [SAMPLE_W:0]   rounded;
    median_word_t               m;
    if (batch_fill < CAPACITY) begin
      pos = batch_fill;
      while (pos > 0 && batch_row[pos-1] > value) begin
        batch_row[pos] = batch_row[pos-1];
        pos--;
      end
      batch_row[pos] = value;
      batch_fill++;
    end else begin
      batch_dropped = 1'b1;
    end
    if (mark) begin
      if (batch_fill % 2 == 1) begin
        m.median = batch_row[batch_fill/2];
      end else begin
        pair_sum = {batch_row[(batch_fill-1)/2][SAMPLE_W-1], batch_row[(batch_fill-1)/2]}
                 + {batch_row[batch_fill/2][SAMPLE_W-1], batch_row[batch_fill/2]};
        // Adding one to a negative sum before the arithmetic halving makes
        // the division truncate toward zero instead of toward minus infinity.
        rounded = pair_sum + {{SAMPLE_W{1'b0}}, pair_sum[SAMPLE_W]};
        m.median = rounded[SAMPLE_W:1];
      end
      m.used_count = COUNT_W'(batch_fill);
      m.overflowed = batch_dropped;
      owed_medians.push_back(m);
      batch_fill = 0;
      batch_dropped = 1'b0;
      batches_in++;
    end
  endtask

  // Receiver state. rx_holding tells the sender to stop idling while the
  // receiver sits on its long hold-off, so that the block backs up.
  int  stall_left = 0;
  int  long_hold_left = 0;
  bit  long_hold_done = 1'b0;
  logic rx_holding = 1'b0;

  // Driver: offers the pending words in order. Valid is raised regardless of
  // ready and the payload is held until the word is taken.
  int           idle_left = 0;
  sample_word_t next_word;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      sample <= '0;
      last_sample <= 1'b0;
      idle_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        take_sample_word(sample, last_sample);
        words_in++;
      end
      // A new word may go out only when no word is being held on the bus.
      if (!in_valid || in_ready) begin
        if (idle_left > 0 && !rx_holding) begin
          idle_left--;
          in_valid <= 1'b0;
        end else if (pending_words.size() != 0 &&
                     !(pending_words[0].hold_for_drain && owed_medians.size() != 0)) begin
          next_word = pending_words.pop_front();
          if (next_word.hold_for_drain) drain_pauses++;
          sample <= next_word.value;
          last_sample <= next_word.mark;
          in_valid <= 1'b1;
          idle_left = quiet ? 0 : pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: takes each median word and checks it against the oldest one
  // owed. It also owns the receiver's ready, with random stalls and, once,
  // a long hold-off while the sender keeps pushing.
  median_word_t want;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_holding <= 1'b0;
      stall_left = 0;
      long_hold_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        medians_seen++;
        if (overflowed === 1'b1) dropped_batches++;
        if (owed_medians.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: unexpected median word %0d count %0d overflowed %0b",
                     median, used_count, overflowed);
        end else begin
          want = owed_medians.pop_front();
          if (median !== want.median || used_count !== want.used_count ||
              overflowed !== want.overflowed) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("ERROR: median word %0d: median %0d (want %0d)",
                       medians_seen, median, want.median);
              $display("  count %0d (want %0d) overflowed %0b (want %0b)",
                       used_count, want.used_count, overflowed, want.overflowed);
            end
          end
        end
      end
      if (!long_hold_done && medians_seen >= 10) begin
        long_hold_done = 1'b1;
        long_hold_left = LONG_HOLD;
      end
      if (long_hold_left > 0) begin
        long_hold_left--;
        out_ready <= 1'b0;
        rx_holding <= 1'b1;
      end else begin
        rx_holding <= 1'b0;
        if (stall_left > 0) begin
          stall_left--;
          out_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 3) == 0) begin
          stall_left = pick_gap();
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  // Watchdog: counts cycles in which no word moves on either channel.
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("ERROR: no word moved for %0d cycles, %0d medians still owed",
               stuck_cycles, owed_medians.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    int len;
    int total;
    int batch_no;

    // Directed batches. Single extremes; a pair of maximums whose sum needs
    // the 33rd bit; a maximum then a minimum, where a subtracting compare
    // would get the order wrong and the halved sum rounds to zero; a small
    // negative sum that must truncate toward zero; and an overfull batch, mostly
    // descending with duplicates and extremes, whose marked last word is itself
    // dropped. The second batch waits for the first median.
    queue_word(S_MIN, 1'b1, 1'b0);
    queue_word(S_MAX, 1'b1, 1'b1);
    queue_word(S_MAX, 1'b0, 1'b0);
    queue_word(S_MAX, 1'b1, 1'b0);
    queue_word(S_MAX, 1'b0, 1'b0);
    queue_word(S_MIN, 1'b1, 1'b0);
    queue_word(-32'sd3, 1'b0, 1'b0);
    queue_word(32'sd0, 1'b1, 1'b0);
    queue_word(S_MAX, 1'b0, 1'b0);
    queue_word(32'sd1000, 1'b0, 1'b0);
    queue_word(32'sd1000, 1'b0, 1'b0);
    queue_word(32'sd7, 1'b0, 1'b0);
    queue_word(32'sd1, 1'b0, 1'b0);
    queue_word(32'sd0, 1'b0, 1'b0);
    queue_word(32'sd0, 1'b0, 1'b0);
    queue_word(-32'sd1, 1'b0, 1'b0);
    queue_word(-32'sd1, 1'b0, 1'b0);
    queue_word(-32'sd7, 1'b0, 1'b0);
    queue_word(-32'sd1000, 1'b0, 1'b0);
    queue_word(S_MIN + 1, 1'b0, 1'b0);
    queue_word(S_MIN, 1'b0, 1'b0);
    queue_word(S_MIN, 1'b0, 1'b0);
    queue_word(32'sd42, 1'b0, 1'b0);
    queue_word(-32'sd42, 1'b0, 1'b0);
    queue_word(32'sd5, 1'b1, 1'b0);

    // Random batches: mostly within capacity, some exactly full, some
    // overfull. Now and then a batch waits until all medians are back.
    total = 0;
    batch_no = 0;
    while (total < RANDOM_WORDS) begin
      case ($urandom_range(0, 19))
        0, 1: len = CAPACITY;
        2, 3: len = $urandom_range(CAPACITY + 1, CAPACITY + 6);
        4, 5, 6: len = $urandom_range(1, 3);
        default: len = $urandom_range(1, CAPACITY);
      endcase
      for (int k = 0; k < len; k++)
        queue_word(pick_sample(), k == len - 1, (batch_no % 30 == 0) && k == 0);
      total += len;
      batch_no++;
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (pending_words.size() != 0 || in_valid) @(posedge clk);
    while (owed_medians.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d sample words in %0d batches; %0d medians checked, %0d flagged drops.",
             words_in, batches_in, medians_seen, dropped_batches);
    $display("Receiver held off %0d cycles once; sender paused for drain %0d times; %0d mismatches.",
             LONG_HOLD, drain_pauses, mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
